// File: rtl/isotp_pkg.sv
// Package for the ISO-TP receive reassembler: modes, codes and item structs.
// No dependencies.
`timescale 1ns / 1ps
package isotp_pkg;
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_CF   = 2'd1;
	localparam logic [1:0] MODE_WAIT = 2'd2;

	localparam logic [2:0] ST_DONE     = 3'd0;
	localparam logic [2:0] ST_OVERFLOW = 3'd1;
	localparam logic [2:0] ST_TIMEOUT  = 3'd2;
	localparam logic [2:0] ST_LOST     = 3'd3;
	localparam logic [2:0] ST_WAITING  = 3'd4;

	localparam logic [1:0] FC_CTS  = 2'd0;
	localparam logic [1:0] FC_WAIT = 2'd1;
	localparam logic [1:0] FC_OVFL = 2'd2;

	localparam logic [2:0] REG_OWN_ID  = 3'd0;
	localparam logic [2:0] REG_STMIN   = 3'd1;
	localparam logic [2:0] REG_TIMEOUT = 3'd2;
	localparam logic [2:0] REG_RETRY   = 3'd3;
	localparam logic [2:0] REG_MAXWAIT = 3'd4;

	localparam logic [3:0] CF_PAYLOAD = 4'd7;
	localparam logic [3:0] FF_PAYLOAD = 4'd6;
	localparam logic [10:0] TIMER_MAX = 11'd2047;

	typedef struct packed {
		logic        opcode;
		logic [15:0] can_id;
		logic [3:0]  frame_length;
		logic [63:0] frame_bytes;
		logic [11:0] buffer_free;
		logic [7:0]  fifo_free_slots;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  write_count;
		logic [55:0] write_bytes;
		logic        clear_buffer;
		logic        status_valid;
		logic [2:0]  status_code;
		logic        fc_send;
		logic [1:0]  fc_flag;
		logic [7:0]  fc_block_size;
		logic [7:0]  fc_separation;
		logic        frame_not_taken;
	} out_item_t;

	typedef struct packed {
		logic        start;
		logic [11:0] dividend;
		logic [2:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [11:0] quotient;
	} div_rsp_t;
endpackage

// File: rtl/isotp_if.sv
// Valid/ready channel interface carrying one payload struct.
// Payload type is supplied per instance.
`timescale 1ns / 1ps
interface isotp_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/isotp_div.sv
// Restoring divider, one quotient bit a cycle, 12-bit by 3-bit.
// Uses isotp_pkg request/response structs.
`timescale 1ns / 1ps
module isotp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  isotp_pkg::div_req_t req,
	output isotp_pkg::div_rsp_t rsp
);
	logic [11:0] quo_q;
	logic [2:0]  rem_q;
	logic [2:0]  den_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [3:0]  trial;

	assign trial = {rem_q, quo_q[11]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 4'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd11) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= 3'(trial - {1'b0, den_q});
				quo_q <= {quo_q[10:0], 1'b1};
			end else begin
				rem_q <= trial[2:0];
				quo_q <= {quo_q[10:0], 1'b0};
			end
		end
	end

	assign rsp = '{done: done_q, quotient: quo_q};
endmodule

// File: rtl/isotp_receive_reassembler.sv
// ISO-TP receive reassembler top level: decode, sequencer and shared divider.
// Depends on isotp_pkg, isotp_if, isotp_div.
//
// Usage: items enter on in_ch (CAN frame offered or 1 ms tick); each item gives
// exactly one result on out_ch. Registers are written on cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block does not enforce it.
// Sequence: an item without flow control passes from acceptance through S_EXEC to
// S_OUT; an item that emits a flow-control frame passes through S_EXEC, S_DIV and
// S_OUT, where S_DIV launches the shared restoring divider, one iteration per
// quotient bit, to compute the block size. One item is in work at a time;
// in_ch.ready is low from acceptance until the result leaves, so the next request
// can be taken at the earliest in the cycle after the result handshake.
// A result waits in the output register while out_ch.ready is low; the block
// takes no new request until it is taken.
// Reset clears the control and result state (not the held item) and loads register
// defaults (timeout 1000 ms, retry 100 ms, 10 wait frames).
`timescale 1ns / 1ps
module isotp_receive_reassembler #(
	parameter int BUFFER_BYTES_MAX = 4095
) (
	input  logic        clk,
	input  logic        arst_n,
	isotp_if.sink       in_ch,
	isotp_if.source     out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam logic [11:0] BUF_MAX = 12'(BUFFER_BYTES_MAX);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [15:0] own_id_q;
	logic [7:0]  stmin_q, maxwait_q;
	logic [10:0] timeout_q, retry_q;

	logic [1:0]  mode_q;
	logic [11:0] msg_len_q, rcvd_q;
	logic [3:0]  seq_q;
	logic [7:0]  fib_q, granted_q, waits_q;
	logic [10:0] elapsed_q;

	isotp_pkg::in_item_t  item_q;
	isotp_pkg::out_item_t res_q;
	logic [1:0]  fc_req_q;
	logic [11:0] fc_free_q;
	logic        fc_zero_slot_q;

	isotp_pkg::div_req_t dreq;
	isotp_pkg::div_rsp_t drsp;

	isotp_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.data = res_q;

	// combinational decode of the held item
	logic [11:0] free_b;
	logic [3:0]  len;
	logic [63:0] data;
	logic [7:0]  b0;
	logic [11:0] remaining;
	logic [2:0]  cf_take;
	logic [11:0] ff_total;
	logic [3:0]  sf_size;
	logic [10:0] el_inc;

	always_comb begin
		free_b = (item_q.buffer_free > BUF_MAX) ? BUF_MAX : item_q.buffer_free;
		len = (item_q.frame_length > 4'd8) ? 4'd8 : item_q.frame_length;
		for (int i = 0; i < 8; i++)
			data[8*i +: 8] = (4'(i) < len) ? item_q.frame_bytes[8*i +: 8] : 8'd0;
		b0 = data[7:0];
		remaining = (rcvd_q < msg_len_q) ? msg_len_q - rcvd_q : 12'd0;
		cf_take = (remaining > 12'(isotp_pkg::CF_PAYLOAD)) ? 3'd7 : remaining[2:0];
		ff_total = {b0[3:0], data[15:8]};
		sf_size = (b0[3:0] > 4'd7) ? 4'd7 : b0[3:0];
		el_inc = (elapsed_q < isotp_pkg::TIMER_MAX) ? elapsed_q + 11'd1 : elapsed_q;
	end

	function automatic logic [55:0] slice(input logic [63:0] d, input logic [1:0] first,
		input logic [2:0] cnt);
		logic [63:0] sh;
		logic [55:0] m;
		begin
			sh = d >> (8 * first);
			m = (56'd1 << (8 * cnt)) - 56'd1;
			slice = sh[55:0] & m;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
			stmin_q <= '0;
			timeout_q <= 11'd1000;
			retry_q <= 11'd100;
			maxwait_q <= 8'd10;
		end else if (cfg_we) begin
			unique case (cfg_index)
				isotp_pkg::REG_OWN_ID:  own_id_q <= cfg_data;
				isotp_pkg::REG_STMIN:   stmin_q <= cfg_data[7:0];
				isotp_pkg::REG_TIMEOUT: timeout_q <= cfg_data[10:0];
				isotp_pkg::REG_RETRY:   retry_q <= cfg_data[10:0];
				isotp_pkg::REG_MAXWAIT: maxwait_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// launch the divider on the first S_DIV cycle when bytes remain
	logic div_started_q;
	logic div_go;
	assign div_go = (state_q == S_DIV) && !div_started_q;

	logic [11:0] fc_rem;
	logic [2:0]  fc_slot;
	logic [11:0] streams;
	logic [7:0]  bs;
	always_comb begin
		fc_rem = (rcvd_q < msg_len_q) ? msg_len_q - rcvd_q : 12'd0;
		fc_slot = (fc_rem > 12'd7) ? 3'd7 : fc_rem[2:0];
		streams = fc_zero_slot_q ? 12'd0 : drsp.quotient;
		if (streams > {4'd0, item_q.fifo_free_slots}) bs = item_q.fifo_free_slots;
		else bs = (streams < 12'd255) ? streams[7:0] : 8'd255;
		dreq.dividend = fc_free_q;
		dreq.divisor = fc_slot;
		dreq.start = div_go && (fc_slot != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= isotp_pkg::MODE_IDLE;
			msg_len_q <= '0;
			rcvd_q <= '0;
			seq_q <= '0;
			fib_q <= '0;
			granted_q <= '0;
			waits_q <= '0;
			elapsed_q <= '0;
			div_started_q <= 1'b0;
			fc_zero_slot_q <= 1'b0;
			fc_req_q <= isotp_pkg::FC_CTS;
			fc_free_q <= '0;
			res_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_ch.valid) state_q <= S_EXEC;
				S_EXEC: begin
					state_q <= S_OUT;
					fc_zero_slot_q <= 1'b0;
					div_started_q <= 1'b0;
					if (item_q.opcode) begin
						elapsed_q <= el_inc;
						if (mode_q == isotp_pkg::MODE_CF) begin
							if (el_inc > timeout_q) begin
								mode_q <= isotp_pkg::MODE_IDLE;
								res_q.clear_buffer <= 1'b1;
								res_q.status_valid <= 1'b1;
								res_q.status_code <= isotp_pkg::ST_TIMEOUT;
							end
						end else if (mode_q == isotp_pkg::MODE_WAIT) begin
							if (el_inc > retry_q) begin
								state_q <= S_DIV;
								if (waits_q < maxwait_q) begin
									mode_q <= isotp_pkg::MODE_CF;
									fc_req_q <= isotp_pkg::FC_CTS;
									fc_free_q <= free_b;
								end else begin
									mode_q <= isotp_pkg::MODE_IDLE;
									res_q.clear_buffer <= 1'b1;
									res_q.status_valid <= 1'b1;
									res_q.status_code <= isotp_pkg::ST_TIMEOUT;
									fc_req_q <= isotp_pkg::FC_OVFL;
									fc_free_q <= BUF_MAX;
								end
							end
						end
					end else if (item_q.can_id == own_id_q) begin
						if (mode_q == isotp_pkg::MODE_WAIT) begin
							res_q.frame_not_taken <= 1'b1;
						end else if (len != 4'd0) begin
							if (mode_q == isotp_pkg::MODE_IDLE) begin
								if (b0[7:4] == 4'd0) begin
									res_q.status_valid <= 1'b1;
									if ({8'd0, sf_size} <= free_b) begin
										res_q.write_count <= sf_size[2:0];
										res_q.write_bytes <= slice(data, 2'd1, sf_size[2:0]);
										res_q.status_code <= isotp_pkg::ST_DONE;
									end else begin
										res_q.clear_buffer <= 1'b1;
										res_q.status_code <= isotp_pkg::ST_OVERFLOW;
									end
								end else if (b0[7:4] == 4'd1 && ff_total >= 12'd8) begin
									msg_len_q <= ff_total;
									state_q <= S_DIV;
									if (free_b >= 12'd6) begin
										res_q.write_count <= 3'd6;
										res_q.write_bytes <= slice(data, 2'd2, 3'd6);
										seq_q <= 4'd1;
										rcvd_q <= 12'd6;
										fib_q <= 8'd0;
										mode_q <= isotp_pkg::MODE_CF;
										fc_req_q <= isotp_pkg::FC_CTS;
										fc_free_q <= free_b - 12'd6;
									end else begin
										rcvd_q <= 12'd0;
										fc_req_q <= isotp_pkg::FC_OVFL;
										fc_free_q <= free_b;
										res_q.clear_buffer <= 1'b1;
										res_q.status_valid <= 1'b1;
										res_q.status_code <= isotp_pkg::ST_OVERFLOW;
									end
								end
							end else if (b0[7:4] == 4'd2) begin
								if (b0[3:0] == seq_q) begin
									if ({9'd0, cf_take} <= free_b) begin
										res_q.write_count <= cf_take;
										res_q.write_bytes <= slice(data, 2'd1, cf_take);
										rcvd_q <= rcvd_q + {9'd0, cf_take};
										seq_q <= seq_q + 4'd1;
										elapsed_q <= '0;
										if (rcvd_q + {9'd0, cf_take} == msg_len_q) begin
											fib_q <= fib_q + 8'd1;
											mode_q <= isotp_pkg::MODE_IDLE;
											res_q.status_valid <= 1'b1;
											res_q.status_code <= isotp_pkg::ST_DONE;
										end else if (fib_q + 8'd1 == granted_q) begin
											fib_q <= 8'd0;
											state_q <= S_DIV;
											fc_req_q <= isotp_pkg::FC_CTS;
											fc_free_q <= free_b - {9'd0, cf_take};
										end else begin
											fib_q <= fib_q + 8'd1;
										end
									end else begin
										state_q <= S_DIV;
										fc_req_q <= isotp_pkg::FC_OVFL;
										fc_free_q <= free_b;
										mode_q <= isotp_pkg::MODE_IDLE;
										res_q.clear_buffer <= 1'b1;
										res_q.status_valid <= 1'b1;
										res_q.status_code <= isotp_pkg::ST_OVERFLOW;
									end
								end else begin
									mode_q <= isotp_pkg::MODE_IDLE;
									res_q.clear_buffer <= 1'b1;
									res_q.status_valid <= 1'b1;
									res_q.status_code <= isotp_pkg::ST_LOST;
								end
							end
						end
					end
				end
				S_DIV: begin
					if (!div_started_q) begin
						div_started_q <= 1'b1;
						fc_zero_slot_q <= (fc_slot == 3'd0);
					end else if (drsp.done || fc_zero_slot_q) begin
						state_q <= S_OUT;
						granted_q <= bs;
						elapsed_q <= '0;
						res_q.fc_send <= 1'b1;
						res_q.fc_block_size <= bs;
						res_q.fc_separation <= stmin_q;
						if (fc_req_q == isotp_pkg::FC_CTS && bs == 8'd0) begin
							res_q.fc_flag <= isotp_pkg::FC_WAIT;
							if (waits_q != 8'd255) waits_q <= waits_q + 8'd1;
							mode_q <= isotp_pkg::MODE_WAIT;
							if (waits_q == 8'd0) begin
								res_q.status_valid <= 1'b1;
								res_q.status_code <= isotp_pkg::ST_WAITING;
							end
						end else begin
							res_q.fc_flag <= fc_req_q;
							waits_q <= 8'd0;
						end
					end
				end
				S_OUT: if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_IDLE && in_ch.valid) res_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) item_q <= in_ch.data;
	end
endmodule

// File: rtl/isotp_checker.sv
// Port-level checker for the ISO-TP receive reassembler, bound to the top.
// Depends on isotp_pkg.
`timescale 1ns / 1ps
module isotp_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input isotp_pkg::out_item_t out_data
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input open while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped under stall");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("second request taken");
	a_nt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_not_taken |-> !out_data.fc_send && out_data.write_count == 3'd0)
		else $error("not-taken frame had effects");
endmodule

bind isotp_receive_reassembler isotp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// File: test/testbench.sv
// Self-checking bench for the ISO-TP receive reassembler: directed table, then random traffic.
// Predicts each result in-line (typed table rows give it directly) and compares it with the block's output.
// Depends on isotp_pkg, isotp_if and isotp_receive_reassembler.
`timescale 1ns / 1ps
module testbench;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int BUF_MAX = 4095;

	typedef struct {
		isotp_pkg::in_item_t  req;
		bit                   typed;
		isotp_pkg::out_item_t want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = isotp_pkg::REG_OWN_ID;
	logic [15:0] cfg_data = '0;

	isotp_if #(.payload_t(isotp_pkg::in_item_t))  in_ch ();
	isotp_if #(.payload_t(isotp_pkg::out_item_t)) out_ch ();

	isotp_receive_reassembler dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	stim_row_t            stim_q[$];
	isotp_pkg::out_item_t result_q[$];
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        mismatches = 0;
	int        quiet_cycles = 0;

	// receiver copy of registers and link state
	logic [15:0] own_id = 16'd0;
	logic [7:0]  stmin = 8'd0;
	int          cf_timeout = 1000;
	int          retry_ms = 100;
	int          max_waits = 10;
	logic [1:0]  link_mode = isotp_pkg::MODE_IDLE;
	int          msg_len = 0;
	int          rx_bytes = 0;
	int          next_seq = 0;
	int          blk_frames = 0;
	int          blk_grant = 0;
	int          wait_cnt = 0;
	int          elapsed = 0;
	int          fifo_free = 0;
	isotp_pkg::out_item_t res;

	function automatic void set_status(logic [2:0] code);
		res.status_valid = 1'b1;
		res.status_code = code;
	endfunction

	function automatic void put_payload(logic [63:0] data, int first, int count);
		logic [63:0] shifted;
		shifted = data >> (8 * first);
		res.write_count = count[2:0];
		res.write_bytes = shifted[55:0] & ((56'h1 << (8 * count)) - 56'h1);
	endfunction

	function automatic void issue_flow_control(logic [1:0] kind, int free_b);
		int remaining;
		int slot;
		int streams;
		int bs;
		logic [1:0] flag;
		remaining = rx_bytes < msg_len ? msg_len - rx_bytes : 0;
		slot = remaining < 7 ? remaining : 7;
		streams = slot != 0 ? free_b / slot : 0;
		flag = kind;
		if (streams > fifo_free) bs = fifo_free;
		else bs = streams < 255 ? streams : 255;
		blk_grant = bs;
		if (kind == isotp_pkg::FC_CTS && bs == 0) begin
			flag = isotp_pkg::FC_WAIT;
			if (wait_cnt < 255) wait_cnt++;
			link_mode = isotp_pkg::MODE_WAIT;
			if (wait_cnt == 1) set_status(isotp_pkg::ST_WAITING);
		end else begin
			wait_cnt = 0;
		end
		elapsed = 0;
		res.fc_send = 1'b1;
		res.fc_flag = flag;
		res.fc_block_size = bs[7:0];
		res.fc_separation = stmin;
	endfunction

	function automatic void take_frame(int len, logic [63:0] data, int free_b);
		logic [7:0] b0;
		int size;
		int total;
		int remaining;
		if (len == 0) return;
		if (len > 8) len = 8;
		if (len < 8) data = data & ((64'h1 << (8 * len)) - 64'h1);
		b0 = data[7:0];
		if (link_mode == isotp_pkg::MODE_IDLE) begin
			if (b0[7:4] == 4'h0) begin
				size = b0[3:0] > 4'd7 ? 7 : int'(b0[3:0]);
				if (size <= free_b) begin
					put_payload(data, 1, size);
					set_status(isotp_pkg::ST_DONE);
				end else begin
					res.clear_buffer = 1'b1;
					set_status(isotp_pkg::ST_OVERFLOW);
				end
			end else if (b0[7:4] == 4'h1) begin
				total = int'({b0[3:0], data[15:8]});
				if (total < 8) return;
				msg_len = total;
				if (6 <= free_b) begin
					put_payload(data, 2, 6);
					next_seq = 1;
					rx_bytes = 6;
					blk_frames = 0;
					link_mode = isotp_pkg::MODE_CF;
					issue_flow_control(isotp_pkg::FC_CTS, free_b - 6);
				end else begin
					rx_bytes = 0;
					issue_flow_control(isotp_pkg::FC_OVFL, free_b);
					res.clear_buffer = 1'b1;
					set_status(isotp_pkg::ST_OVERFLOW);
				end
			end
		end else if (link_mode == isotp_pkg::MODE_CF) begin
			if (b0[7:4] != 4'h2) return;
			if (int'(b0[3:0]) == next_seq) begin
				remaining = rx_bytes < msg_len ? msg_len - rx_bytes : 0;
				if (remaining > 7) remaining = 7;
				if (remaining <= free_b) begin
					put_payload(data, 1, remaining);
					rx_bytes = (rx_bytes + remaining) & 12'hFFF;
					next_seq = (next_seq + 1) & 4'hF;
					blk_frames = (blk_frames + 1) & 8'hFF;
					elapsed = 0;
					if (rx_bytes == msg_len) begin
						link_mode = isotp_pkg::MODE_IDLE;
						set_status(isotp_pkg::ST_DONE);
					end else if (blk_frames == blk_grant) begin
						issue_flow_control(isotp_pkg::FC_CTS, free_b - remaining);
						blk_frames = 0;
					end
				end else begin
					issue_flow_control(isotp_pkg::FC_OVFL, free_b);
					link_mode = isotp_pkg::MODE_IDLE;
					res.clear_buffer = 1'b1;
					set_status(isotp_pkg::ST_OVERFLOW);
				end
			end else begin
				link_mode = isotp_pkg::MODE_IDLE;
				res.clear_buffer = 1'b1;
				set_status(isotp_pkg::ST_LOST);
			end
		end
	endfunction

	function automatic void take_tick(int free_b);
		if (elapsed < 2047) elapsed++;
		if (link_mode == isotp_pkg::MODE_CF) begin
			if (elapsed > cf_timeout) begin
				link_mode = isotp_pkg::MODE_IDLE;
				res.clear_buffer = 1'b1;
				set_status(isotp_pkg::ST_TIMEOUT);
			end
		end else if (link_mode == isotp_pkg::MODE_WAIT) begin
			if (elapsed > retry_ms) begin
				if (wait_cnt < max_waits) begin
					link_mode = isotp_pkg::MODE_CF;
					issue_flow_control(isotp_pkg::FC_CTS, free_b);
				end else begin
					res.clear_buffer = 1'b1;
					issue_flow_control(isotp_pkg::FC_OVFL, BUF_MAX);
					link_mode = isotp_pkg::MODE_IDLE;
					set_status(isotp_pkg::ST_TIMEOUT);
				end
			end
		end
	endfunction

	function automatic isotp_pkg::out_item_t reassemble(isotp_pkg::in_item_t it);
		int free_b;
		free_b = int'(it.buffer_free);
		if (free_b > BUF_MAX) free_b = BUF_MAX;
		res = '0;
		fifo_free = int'(it.fifo_free_slots);
		if (it.opcode) take_tick(free_b);
		else if (it.can_id == own_id) begin
			if (link_mode == isotp_pkg::MODE_WAIT) res.frame_not_taken = 1'b1;
			else take_frame(int'(it.frame_length), it.frame_bytes, free_b);
		end
		return res;
	endfunction

	function automatic isotp_pkg::in_item_t mk_frame(logic [15:0] id, logic [3:0] len,
			logic [63:0] data, logic [11:0] free_b, logic [7:0] slots);
		isotp_pkg::in_item_t it;
		it = '{1'b0, id, len, data, free_b, slots};
		return it;
	endfunction

	function automatic isotp_pkg::in_item_t mk_tick(logic [11:0] free_b, logic [7:0] slots);
		isotp_pkg::in_item_t it;
		it = '{1'b1, 16'($urandom), 4'($urandom), {$urandom, $urandom}, free_b, slots};
		return it;
	endfunction

	function automatic isotp_pkg::out_item_t mk_out(logic [2:0] wc, logic [55:0] wb,
			logic clr, logic sv, logic [2:0] sc, logic fcs, logic [1:0] flag,
			logic [7:0] bs, logic nt);
		isotp_pkg::out_item_t o;
		o = '{wc, wb, clr, sv, sc, fcs, flag, bs, 8'd0, nt};
		return o;
	endfunction

	function automatic void add_row(isotp_pkg::in_item_t it, bit typed,
			isotp_pkg::out_item_t want);
		stim_row_t row;
		row.req = it;
		row.typed = typed;
		row.want = want;
		stim_q.push_back(row);
	endfunction

	function automatic logic [11:0] rand_free();
		return $urandom_range(0, 99) < 15 ? 12'($urandom_range(0, 20)) :
			12'($urandom_range(100, 4095));
	endfunction

	function automatic logic [7:0] rand_slots();
		int k;
		k = $urandom_range(0, 99);
		if (k < 10) return 8'd0;
		if (k < 15) return 8'd255;
		return 8'($urandom_range(1, 10));
	endfunction

	function automatic logic [63:0] with_pci(logic [7:0] b0);
		logic [31:0] lo;
		lo = $urandom;
		return {$urandom, lo[23:0], b0};
	endfunction

	function automatic void gen_random(int n);
		int k;
		int total;
		int left;
		int seq;
		int cfs;
		logic [63:0] d;
		while (stim_q.size() < n) begin
			k = $urandom_range(0, 99);
			if (k < 10) begin
				add_row('{1'($urandom), 16'($urandom), 4'($urandom), {$urandom, $urandom},
					12'($urandom), 8'($urandom)}, 1'b0, '0);
			end else if (k < 15) begin
				repeat ($urandom_range(1, 8))
					add_row(mk_tick(rand_free(), rand_slots()), 1'b0, '0);
			end else if (k < 30) begin
				add_row(mk_frame(own_id, $urandom_range(0, 99) < 80 ? 4'd8 : 4'($urandom),
					with_pci({4'h0, 4'($urandom)}), rand_free(), rand_slots()), 1'b0, '0);
			end else begin
				total = $urandom_range(0, 99) < 5 ? $urandom_range(8, 4095) :
					$urandom_range(8, 70);
				d = with_pci({4'h1, 4'(total >> 8)});
				d[15:8] = total[7:0];
				add_row(mk_frame(own_id, 4'd8, d, rand_free(), rand_slots()), 1'b0, '0);
				left = total - 6;
				seq = 1;
				cfs = 0;
				while (left > 0 && cfs < 40) begin
					if ($urandom_range(0, 99) < 20)
						repeat ($urandom_range(1, 3))
							add_row(mk_tick(rand_free(), rand_slots()), 1'b0, '0);
					if ($urandom_range(0, 99) < 3) seq = seq + $urandom_range(1, 15);
					add_row(mk_frame(own_id, $urandom_range(0, 99) < 90 ? 4'd8 :
						4'($urandom_range(1, 7)), with_pci({4'h2, 4'(seq)}),
						rand_free(), rand_slots()), 1'b0, '0);
					seq++;
					cfs++;
					left -= 7;
				end
			end
		end
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			isotp_pkg::REG_OWN_ID:  own_id = value;
			isotp_pkg::REG_STMIN:   stmin = value[7:0];
			isotp_pkg::REG_TIMEOUT: cf_timeout = int'(value[10:0]);
			isotp_pkg::REG_RETRY:   retry_ms = int'(value[10:0]);
			isotp_pkg::REG_MAXWAIT: max_waits = int'(value[7:0]);
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (stim_q.size() > 0 || result_q.size() > 0) @(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic run_phase(int idle, int stall, logic [15:0] id, logic [7:0] st,
			logic [10:0] tmo, logic [10:0] rty, logic [7:0] mw);
		write_reg(isotp_pkg::REG_OWN_ID, id);
		write_reg(isotp_pkg::REG_STMIN, {8'd0, st});
		write_reg(isotp_pkg::REG_TIMEOUT, {5'd0, tmo});
		write_reg(isotp_pkg::REG_RETRY, {5'd0, rty});
		write_reg(isotp_pkg::REG_MAXWAIT, {8'd0, mw});
		@(negedge clk);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		gen_random(150);
		drain();
	endtask

	// request side: hold an offered request until it is taken
	always @(posedge clk) begin : request_drive
		stim_row_t row;
		if (in_ch.valid && in_ch.ready) begin
			row = stim_q.pop_front();
			res = reassemble(row.req);
			result_q.push_back(row.typed ? row.want : res);
		end
		if (in_ch.valid && !in_ch.ready) begin
		end else if (arst_n && stim_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
			in_ch.valid <= 1'b1;
			in_ch.data <= stim_q[0].req;
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	always @(posedge clk)
		out_ch.ready <= arst_n && $urandom_range(0, 99) >= recv_stall_pct;

	always @(posedge clk) begin : result_check
		isotp_pkg::out_item_t want;
		isotp_pkg::out_item_t got;
		got = out_ch.data;
		if (out_ch.valid && out_ch.ready) begin
			if (result_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = result_q.pop_front();
				if (want !== got) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: wc %0d/%0d wb %h/%h clr %b/%b sv %b/%b sc %0d/%0d",
							want.write_count, got.write_count, want.write_bytes, got.write_bytes,
							want.clear_buffer, got.clear_buffer, want.status_valid,
							got.status_valid, want.status_code, got.status_code);
						$display("  fc %b/%b flag %0d/%0d bs %0d/%0d st %0d/%0d nt %b/%b",
							want.fc_send, got.fc_send, want.fc_flag, got.fc_flag,
							want.fc_block_size, got.fc_block_size, want.fc_separation,
							got.fc_separation, want.frame_not_taken, got.frame_not_taken);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		isotp_pkg::out_item_t z;
		z = '0;
		// own id is zero after reset
		add_row(mk_frame(16'h1234, 4'd8, 64'h0102030405060703, 12'd4095, 8'd8), 1'b1, z);
		add_row(mk_tick(12'd4095, 8'd8), 1'b1, z);
		add_row(mk_frame(16'h0000, 4'd8, 64'hFFEEDDCCBBAA990F, 12'd4095, 8'd8), 1'b1,
			mk_out(3'd7, 56'hFFEEDDCCBBAA99, 1'b0, 1'b1, isotp_pkg::ST_DONE, 1'b0,
				isotp_pkg::FC_CTS, 8'd0, 1'b0));
		add_row(mk_frame(16'h0000, 4'hF, 64'h8877665544332203, 12'd4095, 8'd8), 1'b1,
			mk_out(3'd3, 56'h443322, 1'b0, 1'b1, isotp_pkg::ST_DONE, 1'b0,
				isotp_pkg::FC_CTS, 8'd0, 1'b0));
		add_row(mk_frame(16'h0000, 4'd2, 64'hFFFFFFFFFFFF1107, 12'd4095, 8'd8), 1'b1,
			mk_out(3'd7, 56'h11, 1'b0, 1'b1, isotp_pkg::ST_DONE, 1'b0,
				isotp_pkg::FC_CTS, 8'd0, 1'b0));
		add_row(mk_frame(16'h0000, 4'd8, 64'h0000000000000005, 12'd3, 8'd8), 1'b1,
			mk_out(3'd0, 56'h0, 1'b1, 1'b1, isotp_pkg::ST_OVERFLOW, 1'b0,
				isotp_pkg::FC_CTS, 8'd0, 1'b0));
		add_row(mk_frame(16'h0000, 4'd0, 64'hFFFFFFFFFFFFFF01, 12'd4095, 8'd8), 1'b1, z);
		add_row(mk_frame(16'h0000, 4'd8, 64'h0000000000000510, 12'd4095, 8'd8), 1'b1, z);
		add_row(mk_frame(16'h0000, 4'd8, 64'h0000000000001410, 12'd5, 8'd8), 1'b1,
			mk_out(3'd0, 56'h0, 1'b1, 1'b1, isotp_pkg::ST_OVERFLOW, 1'b1,
				isotp_pkg::FC_OVFL, 8'd0, 1'b0));
		add_row(mk_frame(16'h0000, 4'd8, 64'h0000000000000030, 12'd4095, 8'd8), 1'b1, z);
		add_row(mk_frame(16'h0000, 4'd8, 64'h0000000000000021, 12'd4095, 8'd8), 1'b1, z);
		add_row(mk_frame(16'h0000, 4'd8, 64'hA5A5A5A5A5A5FF1F, 12'd4095, 8'd255), 1'b0, z);
		add_row(mk_frame(16'h0000, 4'd8, 64'h0000000000000025, 12'd4095, 8'd8), 1'b1,
			mk_out(3'd0, 56'h0, 1'b1, 1'b1, isotp_pkg::ST_LOST, 1'b0,
				isotp_pkg::FC_CTS, 8'd0, 1'b0));
		add_row(mk_frame(16'h0000, 4'd8, 64'h665544332211_1E10, 12'd4095, 8'd2), 1'b0, z);
		add_row(mk_frame(16'h0000, 4'd8, 64'h77665544332211_21, 12'd4095, 8'd2), 1'b0, z);
		add_row(mk_frame(16'h0000, 4'd8, 64'h77665544332211_22, 12'd4095, 8'd2), 1'b0, z);
		add_row(mk_frame(16'h0000, 4'd8, 64'h77665544332211_23, 12'd4095, 8'd2), 1'b0, z);
		add_row(mk_frame(16'h0000, 4'd8, 64'h77665544332211_24, 12'd4095, 8'd2), 1'b0, z);
		add_row(mk_frame(16'h0000, 4'd8, 64'h0000000000000A10, 12'd4095, 8'd0), 1'b0, z);
		add_row(mk_frame(16'h0000, 4'd8, 64'h0000000000000021, 12'd4095, 8'd8), 1'b1,
			mk_out(3'd0, 56'h0, 1'b0, 1'b0, isotp_pkg::ST_DONE, 1'b0,
				isotp_pkg::FC_CTS, 8'd0, 1'b1));
		add_row(mk_frame(16'hFFFF, 4'd8, 64'h0000000000000021, 12'd4095, 8'd8), 1'b1, z);
		add_row(mk_tick(12'd0, 8'd0), 1'b0, z);
		add_row(mk_tick(12'd4095, 8'd255), 1'b0, z);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		drain();
		run_phase(0, 0, 16'hFFFF, 8'd255, 11'd1, 11'd1, 8'd1);
		run_phase(83, 0, 16'($urandom), 8'($urandom), 11'd5, 11'd3, 8'd255);
		run_phase(0, 83, 16'h0000, 8'd0, 11'd2046, 11'd2046, 8'd3);
		run_phase(38, 38, 16'h7A5C, 8'h81, 11'd12, 11'd2, 8'd10);
		if (mismatches == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
